>>> src/dsu_pkg.sv
// Shared types, constants and helper functions of the DVB string to UTF-8 transcoder.
package dsu_pkg;

   // Table address layout
   localparam int ADDR_W      = 12;
   localparam int PART_STRIDE = 96;
   localparam int SINGLE_BASE = 1344;
   localparam int LONE_BASE   = 1440;
   localparam int PAIR_BASE   = 1456;
   localparam int PAIR_STRIDE = 52;
   localparam int CAP_W       = 10;

   // Request function codes
   localparam logic FN_TABLE = 1'b0;
   localparam logic FN_TEXT  = 1'b1;

   // Byte values of the selector and text decoding
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
   localparam logic [7:0] BYTE_CTRL_HI  = 8'h9F;
   localparam logic [7:0] BYTE_HIGH_LO  = 8'hA0;
   localparam logic [7:0] BYTE_PFX_LO   = 8'hC0;
   localparam logic [7:0] BYTE_PFX_HI   = 8'hCF;
   localparam logic [7:0] BYTE_UP_LO    = 8'h41;
   localparam logic [7:0] BYTE_UP_HI    = 8'h5A;
   localparam logic [7:0] BYTE_LOW_LO   = 8'h61;
   localparam logic [7:0] BYTE_LOW_HI   = 8'h7A;
   localparam logic [7:0] SEL_UTF8      = 8'h15;
   localparam logic [7:0] SEL_DYNAMIC   = 8'h10;
   localparam logic [7:0] SEL_PART_LO   = 8'h01;
   localparam logic [7:0] SEL_PART_HI   = 8'h0B;
   localparam logic [7:0] SEL_PART_MAX  = 8'h0F;
   localparam logic [3:0] SEL_PART_OFS  = 4'd4;
   localparam logic [3:0] PART_POLISH   = 4'd2;
   localparam logic [3:0] PART_NONE     = 4'd12;

   // Status codes carried by an end marker
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SEL  = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_TRUNC    = 3'd3;
   localparam logic [2:0] ST_NO_TABLE = 3'd4;

   // Override modes
   localparam logic [1:0] OVR_NONE = 2'd0;
   localparam logic [1:0] OVR_8859 = 2'd1;
   localparam logic [1:0] OVR_6937 = 2'd2;
   localparam logic [1:0] OVR_UTF8 = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_OVERRIDE_MODE = 2'd0;
   localparam logic [1:0] REG_OVERRIDE_PART = 2'd1;
   localparam logic [1:0] REG_POLISH_AUTO   = 2'd2;
   localparam logic [1:0] REG_OUT_CAPACITY  = 2'd3;

   typedef enum logic [1:0] {
      CS_8859 = 2'd0,
      CS_6937 = 2'd1,
      CS_UTF8 = 2'd2,
      CS_NONE = 2'd3
   } charset_type;

   // Header parser phase
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_SEL2 = 4'b0010,
      PH_SEL3 = 4'b0100,
      PH_TEXT = 4'b1000
   } phase_type;

   typedef struct packed {
      charset_type cs;
      logic [3:0]  part;
   } cs_sel_type;

   typedef struct packed {
      logic [1:0]       override_mode;
      logic [3:0]       override_part;
      logic             polish_auto;
      logic [CAP_W-1:0] out_capacity;
   } cfg_type;

   // Work handed from the header stage to the emit stage
   typedef struct packed {
      logic       start;
      logic [2:0] err_cand;
      logic       text;
      logic       chk;
      logic       direct;
      logic       lookup;
      logic [7:0] data;
      logic       last;
      logic [2:0] last_cand;
   } desc_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
      logic [2:0] status;
   } res_type;

   function automatic cs_sel_type select_part(input logic [3:0] p, input cs_sel_type cur);
      cs_sel_type r;
      r = cur;
      if (p == 4'd0 || p == PART_NONE) begin
         r.cs = CS_NONE;
      end else begin
         r.cs   = CS_8859;
         r.part = p;
      end
      return r;
   endfunction

   function automatic cs_sel_type apply_override(input cs_sel_type cur, input logic [1:0] mode,
                                                 input logic [3:0] opart);
      cs_sel_type r;
      r = cur;
      unique case (mode)
         OVR_8859: begin
            if (opart != 4'd0) r = select_part(opart, cur);
         end
         OVR_6937: r.cs = CS_6937;
         OVR_UTF8: r.cs = CS_UTF8;
         default:  r = cur;
      endcase
      return r;
   endfunction

endpackage

>>> src/dvb_si_string_to_utf8.sv
// Top level of the DVB service-information string to UTF-8 transcoder.
//
// Feed table words (func 0) and string bytes (func 1) on the req_ channel; the rsp_ channel
// returns UTF-8 bytes and one end marker per string. A string byte is taken every cycle while
// each byte yields at most one beat and rsp_stall is low; after a byte that yields more beats
// (up to three UTF-8 bytes plus the end marker) the next byte waits on req_stall for the
// output serializer, which sends one beat per cycle while rsp_stall is low. Each string byte
// makes one read of the code point table, whose read port is registered and pipelined behind
// the header stage, so the read does not slow the byte rate. Table writes give no beat. The
// table has no reset and no clearing pass: load every entry the strings will reach before
// sending them. Write configuration through csr_ while the block is idle; it is not enforced.
module dvb_si_string_to_utf8 #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [11:0] req_table_addr,
   input  logic [15:0] req_table_word,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_marker,
   output logic [2:0]  rsp_status,
   output logic        rsp_run_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import dsu_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   cfg_type           cfg_ff;
   logic              accept;
   logic              tbl_wr;
   logic              byte_load;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;
   desc_type          desc;

   assign accept    = req_valid && !req_stall;
   assign tbl_wr    = accept && (req_func == FN_TABLE) && (int'(req_table_addr) < TABLE_DEPTH);
   assign byte_load = accept && (req_func == FN_TEXT);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{override_mode: OVR_NONE, override_part: 4'd1, polish_auto: 1'b0,
                     out_capacity: CAP_W'(255)};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_OVERRIDE_MODE: cfg_ff.override_mode <= csr_wdata[1:0];
            REG_OVERRIDE_PART: cfg_ff.override_part <= csr_wdata[3:0];
            REG_POLISH_AUTO:   cfg_ff.polish_auto   <= csr_wdata[0];
            REG_OUT_CAPACITY:  cfg_ff.out_capacity  <= csr_wdata[CAP_W-1:0];
         endcase
      end
   end

   dsu_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (AW'(req_table_addr)),
      .wr_data (req_table_word),
      .rd_en   (byte_load),
      .rd_addr (AW'(rd_addr)),
      .rd_data (rd_data)
   );

   dsu_header u_header (
      .clock     (clock),
      .reset     (reset),
      .accept    (byte_load),
      .data_byte (req_data_byte),
      .first     (req_first),
      .last      (req_last),
      .cfg       (cfg_ff),
      .rd_addr   (rd_addr),
      .desc      (desc)
   );

   dsu_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (byte_load),
      .desc_in        (desc),
      .rd_data        (rd_data),
      .capacity       (cfg_ff.out_capacity),
      .up_stall       (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker),
      .rsp_status     (rsp_status),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

>>> src/dsu_table_ram.sv
// Code point table: one write port and one registered read port.
module dsu_table_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   // Write a table word
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Registered read: data appears in the cycle after the address, held otherwise
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dsu_header.sv
// Header stage: selector parsing, charset and prefix state, table address generation.
module dsu_header (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 data_byte,
   input  logic                       first,
   input  logic                       last,
   input  dsu_pkg::cfg_type           cfg,
   output logic [dsu_pkg::ADDR_W-1:0] rd_addr,
   output dsu_pkg::desc_type          desc
);
   import dsu_pkg::*;

   phase_type   phase_ff, phase_in;
   cs_sel_type  sel_ff, sel_in;
   logic        pend_ff, pend_in;
   logic [7:0]  held_ff, held_in;

   logic            start;
   logic            do_text;
   logic [3:0]      row;
   logic [3:0]      tbl;
   logic [ADDR_W-1:0] addr;
   desc_type        d;

   assign start = first || (phase_ff == PH_IDLE);
   assign row   = held_ff[3:0];
   assign tbl   = (sel_in.part <= 4'd11) ? sel_in.part - 4'd1 : sel_in.part - 4'd2;

   // Decode one string byte against the current header state
   always_comb begin
      phase_in = phase_ff;
      sel_in   = sel_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      do_text  = 1'b0;
      addr     = '0;
      d        = '0;
      d.data   = data_byte;
      d.last   = last;

      if (start) begin
         d.start  = 1'b1;
         pend_in  = 1'b0;
         held_in  = 8'd0;
         phase_in = PH_TEXT;
         if (data_byte >= BYTE_SPACE) begin
            if (cfg.polish_auto) sel_in = select_part(PART_POLISH, sel_ff);
            else sel_in.cs = CS_6937;
            sel_in  = apply_override(sel_in, cfg.override_mode, cfg.override_part);
            do_text = 1'b1;
         end else if (data_byte >= SEL_PART_LO && data_byte <= SEL_PART_HI) begin
            if (cfg.polish_auto && data_byte == SEL_PART_LO) sel_in.cs = CS_6937;
            else sel_in = select_part(data_byte[3:0] + SEL_PART_OFS, sel_ff);
            sel_in = apply_override(sel_in, cfg.override_mode, cfg.override_part);
         end else if (data_byte == SEL_DYNAMIC) begin
            phase_in = PH_SEL2;
         end else if (data_byte == SEL_UTF8) begin
            sel_in.cs = CS_UTF8;
            sel_in    = apply_override(sel_in, cfg.override_mode, cfg.override_part);
         end else begin
            d.err_cand = ST_BAD_SEL;
         end
      end else begin
         unique case (phase_ff)
            PH_SEL2: begin
               if (data_byte != 8'd0) d.err_cand = ST_BAD_SEL;
               phase_in = PH_SEL3;
            end
            PH_SEL3: begin
               if (data_byte == 8'd0 || data_byte > SEL_PART_MAX) begin
                  d.err_cand = ST_BAD_SEL;
               end else begin
                  sel_in = select_part(data_byte[3:0], sel_ff);
                  sel_in = apply_override(sel_in, cfg.override_mode, cfg.override_part);
               end
               phase_in = PH_TEXT;
            end
            default: do_text = 1'b1;
         endcase
      end

      // Classify a text byte and form its table address
      if (do_text) begin
         if (pend_in) begin
            pend_in = 1'b0;
            d.text  = 1'b1;
            if (data_byte == BYTE_SPACE) begin
               d.lookup = 1'b1;
               addr     = ADDR_W'(LONE_BASE) + ADDR_W'(row);
            end else if (data_byte >= BYTE_UP_LO && data_byte <= BYTE_UP_HI) begin
               d.lookup = 1'b1;
               addr     = ADDR_W'(PAIR_BASE) + ADDR_W'(row) * ADDR_W'(PAIR_STRIDE)
                        + ADDR_W'(data_byte - BYTE_UP_LO);
            end else if (data_byte >= BYTE_LOW_LO && data_byte <= BYTE_LOW_HI) begin
               d.lookup = 1'b1;
               addr     = ADDR_W'(PAIR_BASE) + ADDR_W'(row) * ADDR_W'(PAIR_STRIDE)
                        + ADDR_W'(data_byte - BYTE_LOW_LO) + ADDR_W'(26);
            end
         end else if (sel_in.cs == CS_NONE) begin
            d.err_cand = ST_NO_TABLE;
         end else begin
            d.text = 1'b1;
            d.chk  = 1'b1;
            if (sel_in.cs == CS_UTF8 || data_byte <= BYTE_ASCII_HI) begin
               d.direct = 1'b1;
            end else if (data_byte <= BYTE_CTRL_HI) begin
               d.direct = 1'b0;
            end else if (sel_in.cs == CS_8859) begin
               d.lookup = 1'b1;
               addr     = ADDR_W'(tbl) * ADDR_W'(PART_STRIDE)
                        + ADDR_W'(data_byte - BYTE_HIGH_LO);
            end else if (data_byte >= BYTE_PFX_LO && data_byte <= BYTE_PFX_HI) begin
               pend_in = 1'b1;
               held_in = data_byte;
            end else begin
               d.lookup = 1'b1;
               addr     = ADDR_W'(SINGLE_BASE) + ADDR_W'(data_byte - BYTE_HIGH_LO);
            end
         end
      end

      // Close the string
      if (last) begin
         if (phase_in == PH_SEL2 || phase_in == PH_SEL3) d.last_cand = ST_BAD_SEL;
         else if (pend_in) d.last_cand = ST_TRUNC;
         pend_in  = 1'b0;
         phase_in = PH_IDLE;
      end
   end

   // Advance header state on each accepted string byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sel_ff   <= '{cs: CS_8859, part: 4'd0};
         pend_ff  <= 1'b0;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         pend_ff  <= pend_in;
         held_ff  <= held_in;
      end
   end

   assign rd_addr = addr;
   assign desc    = d;

endmodule

>>> src/dsu_emit.sv
// Emit stage: error and space tracking, UTF-8 encoding and the output beat serializer.
module dsu_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  dsu_pkg::desc_type         desc_in,
   input  logic [15:0]               rd_data,
   input  logic [dsu_pkg::CAP_W-1:0] capacity,
   output logic                      up_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_end_marker,
   output logic [2:0]                rsp_status,
   output logic                      rsp_run_last
);
   import dsu_pkg::*;

   desc_type         desc_ff;
   logic             dvalid_ff, dvalid_in;
   logic [2:0]       err_ff, err_in;
   logic [CAP_W-1:0] space_ff, space_in;
   res_type          ser_ff [4];
   res_type          ser_in [4];
   logic [2:0]       cnt_ff, cnt_in;

   logic       pop;
   logic       ser_free;
   logic       fire;
   logic [1:0] len;
   logic [1:0] nd;
   res_type    grp [4];
   logic [2:0] grp_n;

   assign pop      = (cnt_ff != 3'd0) && !rsp_stall;
   assign ser_free = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && pop);
   assign fire     = dvalid_ff && ser_free;
   assign up_stall = dvalid_ff && !fire;
   assign len      = (rd_data <= 16'h007F) ? 2'd1 : ((rd_data <= 16'h07FF) ? 2'd2 : 2'd3);

   // Work out the results of one byte
   always_comb begin
      err_in   = desc_ff.start ? ST_OK : err_ff;
      space_in = desc_ff.start ? capacity : space_ff;
      nd       = 2'd0;
      for (int i = 0; i < 4; i++) grp[i] = '0;

      if (desc_ff.err_cand != ST_OK && err_in == ST_OK) err_in = desc_ff.err_cand;

      if (err_in == ST_OK && desc_ff.text) begin
         if (desc_ff.chk && space_in == '0) begin
            err_in = ST_OVERFLOW;
         end else if (desc_ff.direct) begin
            grp[0].out_byte = desc_ff.data;
            nd       = 2'd1;
            space_in = space_in - CAP_W'(1);
         end else if (desc_ff.lookup && rd_data != 16'd0) begin
            if (CAP_W'(len) > space_in) begin
               err_in = ST_OVERFLOW;
            end else begin
               unique case (len)
                  2'd1: grp[0].out_byte = rd_data[7:0];
                  2'd2: begin
                     grp[0].out_byte = {3'b110, rd_data[10:6]};
                     grp[1].out_byte = {2'b10, rd_data[5:0]};
                  end
                  default: begin
                     grp[0].out_byte = {4'b1110, rd_data[15:12]};
                     grp[1].out_byte = {2'b10, rd_data[11:6]};
                     grp[2].out_byte = {2'b10, rd_data[5:0]};
                  end
               endcase
               nd       = len;
               space_in = space_in - CAP_W'(len);
            end
         end
      end

      // Append the end marker after the data beats
      if (desc_ff.last) begin
         if (desc_ff.last_cand != ST_OK && err_in == ST_OK) err_in = desc_ff.last_cand;
         grp[nd] = '{out_byte: 8'd0, end_marker: 1'b1, status: err_in};
      end
      grp_n = {1'b0, nd} + {2'b00, desc_ff.last};
   end

   // Load a new group or shift out one beat
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < 4; i++) ser_in[i] = ser_ff[i];
      if (fire) begin
         cnt_in = grp_n;
         for (int i = 0; i < 4; i++) ser_in[i] = grp[i];
      end else if (pop) begin
         cnt_in    = cnt_ff - 3'd1;
         ser_in[0] = ser_ff[1];
         ser_in[1] = ser_ff[2];
         ser_in[2] = ser_ff[3];
      end
      dvalid_in = load ? 1'b1 : (fire ? 1'b0 : dvalid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= 1'b0;
         cnt_ff    <= 3'd0;
         err_ff    <= ST_OK;
         space_ff  <= '0;
      end else begin
         dvalid_ff <= dvalid_in;
         cnt_ff    <= cnt_in;
         if (fire) begin
            err_ff   <= err_in;
            space_ff <= space_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load) desc_ff <= desc_in;
      for (int i = 0; i < 4; i++) ser_ff[i] <= ser_in[i];
   end

   assign rsp_valid      = (cnt_ff != 3'd0);
   assign rsp_out_byte   = ser_ff[0].out_byte;
   assign rsp_end_marker = ser_ff[0].end_marker;
   assign rsp_status     = ser_ff[0].status;
   assign rsp_run_last   = (cnt_ff == 3'd1);

endmodule
